// ----- sv/spmc_pkg.sv -----
// shared types and constants for the servo pulse to motor command block
`default_nettype none

package spmc_pkg;

    // motor command codes
    typedef enum logic [1:0] {
        CMD_NONE  = 2'd0,
        CMD_BRAKE = 2'd1,
        CMD_DRIVE = 2'd2,
        CMD_OFF   = 2'd3
    } motor_cmd_t;

    // configuration register indexes
    localparam int unsigned CFG_INDEX_W = 3;
    localparam int unsigned CFG_DATA_W  = 32;

    localparam logic [CFG_INDEX_W-1:0] REG_WIDTH_MIN      = 3'd0;
    localparam logic [CFG_INDEX_W-1:0] REG_WIDTH_MAX      = 3'd1;
    localparam logic [CFG_INDEX_W-1:0] REG_WIDTH_CENTRE   = 3'd2;
    localparam logic [CFG_INDEX_W-1:0] REG_DEAD_ZONE      = 3'd3;
    localparam logic [CFG_INDEX_W-1:0] REG_TIMEOUT_TICKS  = 3'd4;
    localparam logic [CFG_INDEX_W-1:0] REG_STARTUP_PULSES = 3'd5;
    localparam logic [CFG_INDEX_W-1:0] REG_SPEED_SCALE    = 3'd6;

    // register reset values
    localparam logic [15:0] RST_WIDTH_MIN      = 16'd37;
    localparam logic [15:0] RST_WIDTH_MAX      = 16'd187;
    localparam logic [15:0] RST_WIDTH_CENTRE   = 16'd112;
    localparam logic [15:0] RST_DEAD_ZONE      = 16'd7;
    localparam logic [31:0] RST_TIMEOUT_TICKS  = 32'd7501;
    localparam logic [7:0]  RST_STARTUP_PULSES = 8'd5;
    localparam logic [7:0]  RST_SPEED_SCALE    = 8'd8;

    // failsafe blink: led on while the masked timestamp is below the threshold
    localparam logic [14:0] BLINK_MASK     = 15'h7fff;
    localparam logic [14:0] BLINK_ON_BELOW = 15'h0400;

    // speed saturation limits
    localparam logic signed [26:0] SPEED_MAX = 27'sd32767;
    localparam logic signed [26:0] SPEED_MIN = -27'sd32768;

endpackage

`default_nettype wire

// ----- sv/servo_pulse_to_motor_command.sv -----
// servo pulse decoder with failsafe, top level
//
//  channel  direction  handshake            payload
//  in       sink       in_valid / in_ready  pin_level, timestamp
//  out      source     out_valid/out_ready  motor_cmd, speed, led_level
//  cfg      sink       cfg_wr_en            cfg_index, cfg_data
//
// one item per cycle sustained while out_ready is high; a result leaves via both register stages
// the first register stage updates the decoder state and settles the command,
// the second one does the 18x9 speed multiply and saturation
// rst_n clears the decoder state, the stage valids and loads register defaults
// a stall on out holds both stages; in_ready drops only when both are full
`default_nettype none

module servo_pulse_to_motor_command
    import spmc_pkg::*;
(
    input  wire logic                   clk,
    input  wire logic                   rst_n,

    input  wire logic                   in_valid,
    output logic                        in_ready,
    input  wire logic                   pin_level,
    input  wire logic [31:0]            timestamp,

    output logic                        out_valid,
    input  wire logic                   out_ready,
    output logic [1:0]                  motor_cmd,
    output logic signed [15:0]          speed,
    output logic                        led_level,

    input  wire logic                   cfg_wr_en,
    input  wire logic [CFG_INDEX_W-1:0] cfg_index,
    input  wire logic [CFG_DATA_W-1:0]  cfg_data
);

    // configuration registers
    logic [15:0] width_min_reg;
    logic [15:0] width_max_reg;
    logic [15:0] width_centre_reg;
    logic [15:0] dead_zone_reg;
    logic [31:0] timeout_ticks_reg;
    logic [7:0]  startup_pulses_reg;
    logic [7:0]  speed_scale_reg;

    // decoder state
    logic        prev_level_reg;
    logic [31:0] rise_time_reg;
    logic [31:0] last_valid_time_reg;
    logic [7:0]  good_count_reg;
    logic        led_state_reg;

    logic        prev_level_next;
    logic [31:0] rise_time_next;
    logic [31:0] last_valid_time_next;
    logic [7:0]  good_count_next;
    logic        led_state_next;

    // first stage: command settled, speed offset pending
    logic              s1_valid_reg;
    logic              s1_valid_next;
    motor_cmd_t        s1_cmd_reg;
    motor_cmd_t        s1_cmd_next;
    logic signed [17:0] s1_off_reg;
    logic signed [17:0] s1_off_next;
    logic              s1_led_reg;

    // result stage
    logic              out_valid_reg;
    logic              out_valid_next;
    motor_cmd_t        out_cmd_reg;
    logic signed [15:0] out_speed_reg;
    logic signed [15:0] out_speed_next;
    logic              out_led_reg;

    // handshake
    logic in_fire;
    logic out_load;

    // pulse decode
    logic               rise;
    logic               fall;
    logic [31:0]        width;
    logic               good;
    logic signed [17:0] w_s;
    logic signed [17:0] lo_s;
    logic signed [17:0] hi_s;
    logic               in_band;
    logic [31:0]        idle_time;
    logic               timed_out;
    logic signed [26:0] prod;

    // the result stage loads whenever it is empty or being drained
    assign out_load = !out_valid_reg || out_ready;
    assign in_ready = !s1_valid_reg || out_load;
    assign in_fire  = in_valid && in_ready;

    // ---------------------------------------------------------------
    // configuration writes
    // ---------------------------------------------------------------
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            width_min_reg      <= RST_WIDTH_MIN;
            width_max_reg      <= RST_WIDTH_MAX;
            width_centre_reg   <= RST_WIDTH_CENTRE;
            dead_zone_reg      <= RST_DEAD_ZONE;
            timeout_ticks_reg  <= RST_TIMEOUT_TICKS;
            startup_pulses_reg <= RST_STARTUP_PULSES;
            speed_scale_reg    <= RST_SPEED_SCALE;
        end
        else if (cfg_wr_en)
        begin
            unique case (cfg_index)
                REG_WIDTH_MIN:      width_min_reg      <= cfg_data[15:0];
                REG_WIDTH_MAX:      width_max_reg      <= cfg_data[15:0];
                REG_WIDTH_CENTRE:   width_centre_reg   <= cfg_data[15:0];
                REG_DEAD_ZONE:      dead_zone_reg      <= cfg_data[15:0];
                REG_TIMEOUT_TICKS:  timeout_ticks_reg  <= cfg_data;
                REG_STARTUP_PULSES: startup_pulses_reg <= cfg_data[7:0];
                REG_SPEED_SCALE:    speed_scale_reg    <= cfg_data[7:0];
                default:            ; // unused index, write dropped
            endcase
        end
    end

    // ---------------------------------------------------------------
    // pulse decode and state update for the accepted item
    // ---------------------------------------------------------------
    assign rise  = pin_level && !prev_level_reg;
    assign fall  = !pin_level && prev_level_reg;

    // pulse width wraps with the timer
    assign width = timestamp - rise_time_reg;
    assign good  = fall
                && (width >= {16'd0, width_min_reg})
                && (width <= {16'd0, width_max_reg});

    // a good width never exceeds 16 bits, so the low half is the whole width
    assign w_s  = $signed({2'b00, width[15:0]});
    assign lo_s = $signed({2'b00, width_centre_reg}) - $signed({2'b00, dead_zone_reg});
    assign hi_s = $signed({2'b00, width_centre_reg}) + $signed({2'b00, dead_zone_reg});
    assign in_band = (w_s > lo_s) && (w_s < hi_s);

    // a good pulse in this item resets the idle time, so it cannot time out
    assign idle_time = timestamp - last_valid_time_reg;
    assign timed_out = !good && (idle_time > timeout_ticks_reg);

    always_comb
    begin
        prev_level_next      = pin_level;
        rise_time_next       = rise ? timestamp : rise_time_reg;
        last_valid_time_next = good ? timestamp : last_valid_time_reg;
        good_count_next      = good_count_reg;
        led_state_next       = led_state_reg;
        s1_cmd_next          = CMD_NONE;
        s1_off_next          = '0;

        if (good)
        begin
            if (good_count_reg < startup_pulses_reg)
            begin
                // still in startup, count reaches at most 255 so no wrap
                good_count_next = good_count_reg + 8'd1;
            end
            else
            begin
                led_state_next = 1'b1;
                if (in_band)
                begin
                    s1_cmd_next = CMD_BRAKE;
                end
                else
                begin
                    s1_cmd_next = CMD_DRIVE;
                    // offset from the nearer band edge, sign gives direction
                    s1_off_next = (w_s >= hi_s) ? (w_s - hi_s) : (w_s - lo_s);
                end
            end
        end

        if (timed_out)
        begin
            // failsafe: motor off, slow blink, redo startup
            s1_cmd_next     = CMD_OFF;
            s1_off_next     = '0;
            led_state_next  = ((timestamp[14:0] & BLINK_MASK) < BLINK_ON_BELOW);
            good_count_next = '0;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            prev_level_reg      <= 1'b0;
            rise_time_reg       <= '0;
            last_valid_time_reg <= '0;
            good_count_reg      <= '0;
            led_state_reg       <= 1'b0;
        end
        else if (in_fire)
        begin
            prev_level_reg      <= prev_level_next;
            rise_time_reg       <= rise_time_next;
            last_valid_time_reg <= last_valid_time_next;
            good_count_reg      <= good_count_next;
            led_state_reg       <= led_state_next;
        end
    end

    // ---------------------------------------------------------------
    // first stage register
    // ---------------------------------------------------------------
    always_comb
    begin
        priority if (in_fire)
            s1_valid_next = 1'b1;
        else if (out_load)
            s1_valid_next = 1'b0;
        else
            s1_valid_next = s1_valid_reg;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            s1_valid_reg <= 1'b0;
        else
            s1_valid_reg <= s1_valid_next;
    end

    always_ff @(posedge clk)
    begin
        if (in_fire)
        begin
            s1_cmd_reg <= s1_cmd_next;
            s1_off_reg <= s1_off_next;
            s1_led_reg <= led_state_next;
        end
    end

    // ---------------------------------------------------------------
    // speed: offset times scale, saturated to 16 bits signed
    // ---------------------------------------------------------------
    assign prod = 27'(s1_off_reg) * 27'($signed({1'b0, speed_scale_reg}));

    always_comb
    begin
        priority if (prod > SPEED_MAX)
            out_speed_next = SPEED_MAX[15:0];
        else if (prod < SPEED_MIN)
            out_speed_next = SPEED_MIN[15:0];
        else
            out_speed_next = prod[15:0];
    end

    // ---------------------------------------------------------------
    // result register
    // ---------------------------------------------------------------
    assign out_valid_next = out_load ? s1_valid_reg : out_valid_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            out_valid_reg <= 1'b0;
        else
            out_valid_reg <= out_valid_next;
    end

    always_ff @(posedge clk)
    begin
        if (out_load && s1_valid_reg)
        begin
            out_cmd_reg   <= s1_cmd_reg;
            out_speed_reg <= out_speed_next;
            out_led_reg   <= s1_led_reg;
        end
    end

    assign out_valid = out_valid_reg;
    assign motor_cmd = out_cmd_reg;
    assign speed     = out_speed_reg;
    assign led_level = out_led_reg;

    // ---------------------------------------------------------------
    // assertions
    // ---------------------------------------------------------------

    // speed carries a value only with a drive command
    assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && (motor_cmd != CMD_DRIVE) |-> (speed == 16'sd0))
    else $error("speed nonzero without drive command");

    // a timed-out item leaves the startup count cleared
    assert property (@(posedge clk) disable iff (!rst_n)
        s1_valid_reg && (s1_cmd_reg == CMD_OFF) && !$past(in_fire == 1'b0)
        |-> (good_count_reg == 8'd0))
    else $error("startup count not cleared on timeout");

    // brake or drive always comes with the led lit
    assert property (@(posedge clk) disable iff (!rst_n)
        s1_valid_reg && ((s1_cmd_reg == CMD_BRAKE) || (s1_cmd_reg == CMD_DRIVE))
        |-> s1_led_reg)
    else $error("motor command issued with led off");

    // a held result stage keeps the first stage from being overwritten
    assert property (@(posedge clk) disable iff (!rst_n)
        s1_valid_reg && out_valid_reg && !out_ready |-> !in_ready)
    else $error("input taken while both stages are full");

endmodule

`default_nettype wire
